// ===== rtl/slr_pkg.sv =====
// slr_pkg: shared types and codes for the styled line rasterizer
`timescale 1ns / 1ps

package slr_pkg;

   // line style register
   typedef logic [2:0] line_style_type;

   localparam line_style_type STYLE_SOLID  = 3'd0;
   localparam line_style_type STYLE_DOTTED = 3'd1;
   localparam line_style_type STYLE_DASHED = 3'd2;
   localparam line_style_type STYLE_BROAD  = 3'd3;
   localparam line_style_type STYLE_NONE   = 3'd4;

   // request modes
   typedef logic mode_type;

   localparam mode_type MODE_START = 1'b0;
   localparam mode_type MODE_STEP  = 1'b1;

   // phase counters for the dotted and dashed patterns
   typedef logic [1:0] phase3_type;
   typedef logic [3:0] phase10_type;

   localparam phase3_type  PHASE3_LAST  = 2'd2;
   localparam phase10_type PHASE10_LAST = 4'd9;
   localparam phase10_type DASH_ON_LEN  = 4'd5;

   // broad style walks a 3x3 neighbourhood, y offset inner
   typedef logic [3:0] nbr_type;
   typedef logic [1:0] nbr_row_type;

   localparam nbr_type     NBR_BEFORE_LAST = 4'd7;
   localparam nbr_row_type NBR_ROW_LAST    = 2'd2;

endpackage

// ===== rtl/slr_if.sv =====
// slr_if: request, response and csr channel interfaces of the line rasterizer
`timescale 1ns / 1ps

interface slr_req_if #(parameter int COORD_BITS = 10);
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;

   modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface slr_rsp_if #(parameter int COORD_BITS = 10);
   logic                         valid;
   logic                         ready;
   logic                         pixel_valid;
   logic signed [COORD_BITS+1:0] pixel_x;
   logic signed [COORD_BITS+1:0] pixel_y;
   logic                         last_of_step;
   logic                         line_done;

   modport source (output valid, pixel_valid, pixel_x, pixel_y, last_of_step, line_done,
                   input ready);
   modport sink   (input valid, pixel_valid, pixel_x, pixel_y, last_of_step, line_done,
                   output ready);
endinterface

interface slr_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/styled_line_rasterizer_unit.sv =====
// styled_line_rasterizer_unit: Bresenham line rasterizer with line styles
`timescale 1ns / 1ps

// Usage
//   req_bus: a start request (mode 0) loads both endpoints and returns nothing;
//     a step request (mode 1) plots the current point in the selected style and
//     advances the line by one Bresenham step.
//   rsp_bus: one response per step request, nine for the broad style; the last
//     one of a step carries last_of_step, line_done flags the final step.
//   csr_bus: writes the 3-bit line style; always ready, write only while idle.
// Latency: the first response of a step is valid the cycle after the request
//   is taken.
// Throughput: one request per cycle for solid, dotted, dashed and blank styles
//   while rsp_bus is ready; a broad step holds the response register until
//   its nine responses have left, which is what sets the rate for that style.
// Reset: no line is active and the style is solid; a step without a line gives
//   one empty response with line_done set.
// Stall: when rsp_bus is not ready the response register holds and req_bus
//   ready drops, except that a new request is taken in the cycle the last
//   response of the previous step leaves.

module styled_line_rasterizer_unit
   import slr_pkg::*;
#(
   parameter int COORD_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   slr_req_if.sink   req_bus,
   slr_rsp_if.source rsp_bus,
   slr_csr_if.sink   csr_bus
);

   localparam int PIX_BITS = COORD_BITS + 2;
   localparam int ERR_BITS = COORD_BITS + 3;

   // line state
   line_style_type               line_style_ff;
   logic                         line_active_ff, line_active_in;
   logic [COORD_BITS-1:0]        cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]        cur_y_ff, cur_y_in;
   logic signed [ERR_BITS-1:0]   error_term_ff, error_term_in;
   logic [COORD_BITS-1:0]        major_len_ff, major_len_in;
   logic [COORD_BITS-1:0]        minor_len_ff, minor_len_in;
   logic signed [1:0]            step_sign_x_ff, step_sign_x_in;
   logic signed [1:0]            step_sign_y_ff, step_sign_y_in;
   logic                         axes_swapped_ff, axes_swapped_in;
   logic [COORD_BITS-1:0]        step_index_ff, step_index_in;
   phase3_type                   phase_mod3_ff, phase_mod3_in;
   phase10_type                  phase_mod10_ff, phase_mod10_in;

   // response register
   logic                         busy_ff, busy_in;
   logic                         pix_valid_ff, pix_valid_in;
   logic [PIX_BITS-1:0]          pix_x_ff, pix_x_in;
   logic [PIX_BITS-1:0]          pix_y_ff, pix_y_in;
   logic                         last_ff, last_in;
   logic                         done_ff, done_in;
   logic                         broad_ff, broad_in;
   nbr_type                      nbr_ff, nbr_in;
   nbr_row_type                  nbr_row_ff, nbr_row_in;

   logic                         req_take;
   logic                         rsp_take;
   logic                         step_take;
   logic                         start_take;

   // setup terms
   logic signed [COORD_BITS:0]   dx, dy;
   logic [COORD_BITS-1:0]        adx, ady;
   logic                         swap_new;

   // step terms
   logic                         step_done;
   logic                         emit;
   logic                         err_ge;
   logic                         move_x, move_y;
   logic [COORD_BITS-1:0]        sign_ext_x, sign_ext_y;
   logic [ERR_BITS-1:0]          two_major, two_minor;

   // handshakes
   assign rsp_take   = rsp_bus.valid & rsp_bus.ready;
   assign req_bus.ready = ~busy_ff | (rsp_bus.ready & last_ff);
   assign req_take   = req_bus.valid & req_bus.ready;
   assign step_take  = req_take & (req_bus.mode == MODE_STEP);
   assign start_take = req_take & (req_bus.mode == MODE_START);
   assign csr_bus.ready = 1'b1;

   // line setup from endpoints
   always_comb begin
      dx = $signed({1'b0, req_bus.end_x}) - $signed({1'b0, req_bus.start_x});
      dy = $signed({1'b0, req_bus.end_y}) - $signed({1'b0, req_bus.start_y});
      adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      swap_new = ady > adx;
   end

   // bresenham step and style decode
   always_comb begin
      step_done  = ({1'b0, step_index_ff} + 1'b1) >= {1'b0, major_len_ff};
      err_ge     = ~error_term_ff[ERR_BITS-1];
      move_x     = axes_swapped_ff ? err_ge : 1'b1;
      move_y     = axes_swapped_ff ? 1'b1 : err_ge;
      sign_ext_x = {{(COORD_BITS-2){step_sign_x_ff[1]}}, step_sign_x_ff};
      sign_ext_y = {{(COORD_BITS-2){step_sign_y_ff[1]}}, step_sign_y_ff};
      two_major  = {2'b00, major_len_ff, 1'b0};
      two_minor  = {2'b00, minor_len_ff, 1'b0};
      unique case (line_style_ff)
         STYLE_SOLID:  emit = 1'b1;
         STYLE_DOTTED: emit = phase_mod3_ff != '0;
         STYLE_DASHED: emit = phase_mod10_ff < DASH_ON_LEN;
         STYLE_BROAD:  emit = 1'b1;
         default:      emit = 1'b0;
      endcase
   end

   // next line state
   always_comb begin
      line_active_in  = line_active_ff;
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      error_term_in   = error_term_ff;
      major_len_in    = major_len_ff;
      minor_len_in    = minor_len_ff;
      step_sign_x_in  = step_sign_x_ff;
      step_sign_y_in  = step_sign_y_ff;
      axes_swapped_in = axes_swapped_ff;
      step_index_in   = step_index_ff;
      phase_mod3_in   = phase_mod3_ff;
      phase_mod10_in  = phase_mod10_ff;
      priority if (start_take) begin
         cur_x_in        = req_bus.start_x;
         cur_y_in        = req_bus.start_y;
         step_sign_x_in  = (dx == '0) ? 2'sd0 : (dx[COORD_BITS] ? -2'sd1 : 2'sd1);
         step_sign_y_in  = (dy == '0) ? 2'sd0 : (dy[COORD_BITS] ? -2'sd1 : 2'sd1);
         axes_swapped_in = swap_new;
         major_len_in    = swap_new ? ady : adx;
         minor_len_in    = swap_new ? adx : ady;
         error_term_in   = $signed({2'b00, minor_len_in, 1'b0})
                         - $signed({3'b000, major_len_in});
         step_index_in   = '0;
         phase_mod3_in   = '0;
         phase_mod10_in  = '0;
         line_active_in  = major_len_in != '0;
      end else if (step_take && line_active_ff) begin
         if (move_x) cur_x_in = cur_x_ff + sign_ext_x;
         if (move_y) cur_y_in = cur_y_ff + sign_ext_y;
         error_term_in  = $signed(ERR_BITS'(error_term_ff - (err_ge ? two_major : '0)
                                            + two_minor));
         step_index_in  = step_index_ff + 1'b1;
         phase_mod3_in  = (phase_mod3_ff == PHASE3_LAST) ? '0 : phase_mod3_ff + 1'b1;
         phase_mod10_in = (phase_mod10_ff == PHASE10_LAST) ? '0 : phase_mod10_ff + 1'b1;
         if (step_done) line_active_in = 1'b0;
      end else begin
      end
   end

   // next response register: load on a step, walk the broad block on each take
   always_comb begin
      busy_in      = busy_ff;
      pix_valid_in = pix_valid_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      broad_in     = broad_ff;
      nbr_in       = nbr_ff;
      nbr_row_in   = nbr_row_ff;
      priority if (step_take) begin
         busy_in    = 1'b1;
         nbr_in     = '0;
         nbr_row_in = '0;
         if (!line_active_ff) begin
            pix_valid_in = 1'b0;
            pix_x_in     = '0;
            pix_y_in     = '0;
            last_in      = 1'b1;
            done_in      = 1'b1;
            broad_in     = 1'b0;
         end else begin
            done_in      = step_done;
            pix_valid_in = emit;
            broad_in     = line_style_ff == STYLE_BROAD;
            last_in      = ~broad_in;
            if (!emit) begin
               pix_x_in = '0;
               pix_y_in = '0;
            end else if (broad_in) begin
               pix_x_in = {2'b00, cur_x_ff} - 1'b1;
               pix_y_in = {2'b00, cur_y_ff} - 1'b1;
            end else begin
               pix_x_in = {2'b00, cur_x_ff};
               pix_y_in = {2'b00, cur_y_ff};
            end
         end
      end else if (rsp_take) begin
         if (last_ff) begin
            busy_in = 1'b0;
         end else begin
            nbr_in  = nbr_ff + 1'b1;
            last_in = nbr_ff == NBR_BEFORE_LAST;
            if (nbr_row_ff == NBR_ROW_LAST) begin
               nbr_row_in = '0;
               pix_x_in   = pix_x_ff + 1'b1;
               pix_y_in   = pix_y_ff - PIX_BITS'(2);
            end else begin
               nbr_row_in = nbr_row_ff + 1'b1;
               pix_y_in   = pix_y_ff + 1'b1;
            end
         end
      end else begin
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_style_ff  <= STYLE_SOLID;
         line_active_ff <= 1'b0;
         busy_ff        <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) line_style_ff <= csr_bus.data;
         line_active_ff <= line_active_in;
         busy_ff        <= busy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_x_ff        <= cur_x_in;
      cur_y_ff        <= cur_y_in;
      error_term_ff   <= error_term_in;
      major_len_ff    <= major_len_in;
      minor_len_ff    <= minor_len_in;
      step_sign_x_ff  <= step_sign_x_in;
      step_sign_y_ff  <= step_sign_y_in;
      axes_swapped_ff <= axes_swapped_in;
      step_index_ff   <= step_index_in;
      phase_mod3_ff   <= phase_mod3_in;
      phase_mod10_ff  <= phase_mod10_in;
      pix_valid_ff    <= pix_valid_in;
      pix_x_ff        <= pix_x_in;
      pix_y_ff        <= pix_y_in;
      last_ff         <= last_in;
      done_ff         <= done_in;
      broad_ff        <= broad_in;
      nbr_ff          <= nbr_in;
      nbr_row_ff      <= nbr_row_in;
   end

   // response outputs
   assign rsp_bus.valid        = busy_ff;
   assign rsp_bus.pixel_valid  = pix_valid_ff;
   assign rsp_bus.pixel_x      = $signed(pix_x_ff);
   assign rsp_bus.pixel_y      = $signed(pix_y_ff);
   assign rsp_bus.last_of_step = last_ff;
   assign rsp_bus.line_done    = done_ff;

   // a new request only enters as the last response of the previous step leaves
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_take && busy_ff) |-> (rsp_bus.ready && last_ff))
      else $error("request taken while a step still has responses pending");

   // a step with no active line answers with one empty, final response
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      (step_take && !line_active_ff) |=>
         (rsp_bus.valid && !rsp_bus.pixel_valid && rsp_bus.last_of_step && rsp_bus.line_done))
      else $error("step without a line gave a wrong response");

   // the broad walk never runs past the ninth pixel, and ends exactly there
   a_broad_walk: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && broad_ff) |-> ((nbr_ff <= 4'd8) && (last_ff == (nbr_ff == 4'd8))))
      else $error("broad neighbourhood walk out of step");

   // a finished line is no longer active
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (step_take && line_active_ff && step_done) |=> !line_active_ff)
      else $error("line still active after its final step");

endmodule

// ===== sim/line_raster_checker.sv =====
// line_raster_checker: predicts and checks the pixel responses of the styled line rasterizer
`timescale 1ns / 1ps

module line_raster_checker
   import slr_pkg::*;
#(
   parameter int COORD_BITS = 10
) (
   input  logic      clock,
   input  logic      reset,
   slr_req_if        req_bus,
   slr_rsp_if        rsp_bus,
   slr_csr_if        csr_bus,
   output int        fail_count,
   output int        rsp_pending,
   output int        responses_seen,
   output int        pixels_seen
);

   localparam int REPORT_LIMIT = 10;

   typedef logic signed [COORD_BITS+1:0] pix_type;

   typedef struct packed {
      logic    pixel_valid;
      pix_type pixel_x;
      pix_type pixel_y;
      logic    last_of_step;
      logic    line_done;
   } pixel_rsp_type;

   pixel_rsp_type expected_pixels[$];

   // predicted line state
   line_style_type              style_reg;
   logic signed [COORD_BITS:0]  pos_x, pos_y;
   logic signed [COORD_BITS+2:0] bres_err;
   logic [COORD_BITS-1:0]       major_steps, minor_steps;
   logic signed [1:0]           dir_x, dir_y;
   logic                        steep;
   logic [COORD_BITS-1:0]       step_count;
   phase3_type                  dot_phase;
   phase10_type                 dash_phase;
   logic                        drawing;

   int errors;
   int rsp_total;
   int pix_total;

   // queue one predicted response; coordinates read zero when no pixel
   function automatic void queue_pixel(logic valid, int x, int y, logic last, logic done);
      pixel_rsp_type e;
      e.pixel_valid  = valid;
      e.pixel_x      = valid ? x[COORD_BITS+1:0] : '0;
      e.pixel_y      = valid ? y[COORD_BITS+1:0] : '0;
      e.last_of_step = last;
      e.line_done    = done;
      expected_pixels.push_back(e);
   endfunction

   always @(posedge clock) begin
      pixel_rsp_type got;
      pixel_rsp_type want;
      int dx, dy, adx, ady, maj, mnr, n, err_i;
      logic done;
      if (reset) begin
         style_reg   = STYLE_SOLID;
         pos_x       = '0;
         pos_y       = '0;
         bres_err    = '0;
         major_steps = '0;
         minor_steps = '0;
         dir_x       = '0;
         dir_y       = '0;
         steep       = 1'b0;
         step_count  = '0;
         dot_phase   = '0;
         dash_phase  = '0;
         drawing     = 1'b0;
         errors      = 0;
         rsp_total   = 0;
         pix_total   = 0;
         expected_pixels.delete();
      end else begin
         // compare the response leaving the block against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.pixel_valid  = rsp_bus.pixel_valid;
            got.pixel_x      = rsp_bus.pixel_x;
            got.pixel_y      = rsp_bus.pixel_y;
            got.last_of_step = rsp_bus.last_of_step;
            got.line_done    = rsp_bus.line_done;
            rsp_total++;
            if (got.pixel_valid === 1'b1)
               pix_total++;
            if (expected_pixels.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected response %0d: valid=%0b x=%0d y=%0d last=%0b done=%0b",
                           rsp_total, got.pixel_valid, got.pixel_x, got.pixel_y,
                           got.last_of_step, got.line_done);
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("response %0d mismatch: expected valid=%0b x=%0d y=%0d last=%0b done=%0b",
                              rsp_total, want.pixel_valid, want.pixel_x, want.pixel_y,
                              want.last_of_step, want.line_done);
                     $display("   got valid=%0b x=%0d y=%0d last=%0b done=%0b",
                              got.pixel_valid, got.pixel_x, got.pixel_y,
                              got.last_of_step, got.line_done);
                  end
               end
            end
         end

         // accepted request: start loads the line, step plots and advances
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.mode == MODE_START) begin
               dx    = int'(req_bus.end_x) - int'(req_bus.start_x);
               dy    = int'(req_bus.end_y) - int'(req_bus.start_y);
               adx   = (dx < 0) ? -dx : dx;
               ady   = (dy < 0) ? -dy : dy;
               steep = ady > adx;
               maj   = steep ? ady : adx;
               mnr   = steep ? adx : ady;
               pos_x = $signed({1'b0, req_bus.start_x});
               pos_y = $signed({1'b0, req_bus.start_y});
               dir_x = (dx > 0) ? 2'sd1 : ((dx < 0) ? -2'sd1 : 2'sd0);
               dir_y = (dy > 0) ? 2'sd1 : ((dy < 0) ? -2'sd1 : 2'sd0);
               major_steps = maj[COORD_BITS-1:0];
               minor_steps = mnr[COORD_BITS-1:0];
               err_i       = 2 * mnr - maj;
               bres_err    = err_i[COORD_BITS+2:0];
               step_count  = '0;
               dot_phase   = '0;
               dash_phase  = '0;
               drawing     = maj != 0;
            end else if (!drawing) begin
               queue_pixel(1'b0, 0, 0, 1'b1, 1'b1);
            end else begin
               done = (int'(step_count) + 1) >= int'(major_steps);
               n    = 0;
               case (style_reg)
                  STYLE_SOLID: begin
                     queue_pixel(1'b1, int'(pos_x), int'(pos_y), 1'b1, done);
                     n = 1;
                  end
                  STYLE_DOTTED: begin
                     if (dot_phase != '0) begin
                        queue_pixel(1'b1, int'(pos_x), int'(pos_y), 1'b1, done);
                        n = 1;
                     end
                  end
                  STYLE_DASHED: begin
                     if (dash_phase < DASH_ON_LEN) begin
                        queue_pixel(1'b1, int'(pos_x), int'(pos_y), 1'b1, done);
                        n = 1;
                     end
                  end
                  STYLE_BROAD: begin
                     // x offset outer, y offset inner
                     for (int ox = -1; ox <= 1; ox++) begin
                        for (int oy = -1; oy <= 1; oy++) begin
                           queue_pixel(1'b1, int'(pos_x) + ox, int'(pos_y) + oy, n == 8, done);
                           n++;
                        end
                     end
                  end
                  default: ;
               endcase
               // skipped step still answers with one empty response
               if (n == 0)
                  queue_pixel(1'b0, 0, 0, 1'b1, done);

               // one bresenham step
               err_i = int'(bres_err);
               if (err_i >= 0) begin
                  if (steep)
                     pos_x = pos_x + dir_x;
                  else
                     pos_y = pos_y + dir_y;
                  err_i = err_i - 2 * int'(major_steps);
               end
               if (steep)
                  pos_y = pos_y + dir_y;
               else
                  pos_x = pos_x + dir_x;
               err_i      = err_i + 2 * int'(minor_steps);
               bres_err   = err_i[COORD_BITS+2:0];
               step_count = step_count + 1'b1;
               dot_phase  = (dot_phase >= PHASE3_LAST) ? '0 : dot_phase + 1'b1;
               dash_phase = (dash_phase >= PHASE10_LAST) ? '0 : dash_phase + 1'b1;
               if (done)
                  drawing = 1'b0;
            end
         end

         // style register write
         if (csr_bus.valid && csr_bus.ready)
            style_reg = csr_bus.data;
      end

      fail_count     <= errors;
      rsp_pending    <= expected_pixels.size();
      responses_seen <= rsp_total;
      pixels_seen    <= pix_total;
   end

endmodule

// ===== sim/testbench.sv =====
// testbench: stimulus, pacing and verdict for the styled line rasterizer
`timescale 1ns / 1ps

module testbench;
   import slr_pkg::*;

   localparam int COORD_BITS  = 10;
   localparam int CLK_PERIOD  = 10;
   localparam int RESET_LEN   = 4;
   localparam int ITEM_TARGET = 430;
   localparam int PHASE_ITEMS = 45;
   localparam int SETTLE_LEN  = 4;
   localparam int TAIL_LEN    = 20;
   localparam int HOLD_LEN    = 300;
   localparam int IDLE_LIMIT  = 3000;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

   // style codes the package leaves unnamed; the block draws nothing for them
   localparam line_style_type STYLE_SPARE_A = 3'd5;
   localparam line_style_type STYLE_SPARE_B = 3'd6;
   localparam line_style_type STYLE_SPARE_C = 3'd7;

   typedef logic [COORD_BITS-1:0] coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slr_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   slr_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();
   slr_csr_if                            csr_bus ();

   int fail_count;
   int rsp_pending;
   int responses_seen;
   int pixels_seen;

   int  items_sent   = 0;
   int  starts_sent  = 0;
   int  steps_sent   = 0;
   int  style_writes = 0;
   int  idle_cycles  = 0;
   bit  no_idle      = 1'b0;
   bit  hold_armed   = 1'b0;

   styled_line_rasterizer_unit #(.COORD_BITS(COORD_BITS)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   line_raster_checker #(.COORD_BITS(COORD_BITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .fail_count     (fail_count),
      .rsp_pending    (rsp_pending),
      .responses_seen (responses_seen),
      .pixels_seen    (pixels_seen)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // gap before a request: mostly none or short, a few long
   function automatic int gap_len();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 19);
      if (r < 12)
         return 0;
      if (r < 18)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // coordinate that lands on an edge of the field now and then
   function automatic int pick_coord();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return COORD_MAX;
         default: return $urandom_range(0, COORD_MAX);
      endcase
   endfunction

   // second endpoint near the first, reflected back into the field if needed
   function automatic int near_coord(int c, int span);
      int v;
      v = c + $urandom_range(0, 2 * span) - span;
      if (v < 0 || v > COORD_MAX)
         v = 2 * c - v;
      return v;
   endfunction

   // offer one request and wait for it to be taken
   task automatic offer(input mode_type mode, input coord_type x0, input coord_type y0,
                        input coord_type x1, input coord_type y1);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.start_x <= x0;
      req_bus.start_y <= y0;
      req_bus.end_x   <= x1;
      req_bus.end_y   <= y1;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (mode == MODE_START)
         starts_sent++;
      else
         steps_sent++;
   endtask

   // step request; the coordinate fields carry junk the block must ignore
   task automatic step_once();
      offer(MODE_STEP, coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
            coord_type'($urandom));
   endtask

   task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                            input int nsteps);
      offer(MODE_START, coord_type'(x0), coord_type'(y0), coord_type'(x1), coord_type'(y1));
      repeat (nsteps) step_once();
   endtask

   // mostly short complete lines, some long abandoned ones, some stray steps
   task automatic random_line();
      int kind, x0, y0, x1, y1, span, maj, nsteps;
      kind = $urandom_range(0, 19);
      x0   = pick_coord();
      y0   = pick_coord();
      if (kind < 17) begin
         span = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
         x1   = near_coord(x0, span);
         y1   = near_coord(y0, span);
         maj  = (x1 > x0) ? x1 - x0 : x0 - x1;
         if (((y1 > y0) ? y1 - y0 : y0 - y1) > maj)
            maj = (y1 > y0) ? y1 - y0 : y0 - y1;
         if ($urandom_range(0, 9) == 0)
            nsteps = $urandom_range(0, maj);
         else
            nsteps = maj + $urandom_range(0, 1);
         draw_line(x0, y0, x1, y1, nsteps);
      end else if (kind < 19) begin
         draw_line(x0, y0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(1, 8));
      end else begin
         repeat ($urandom_range(1, 3)) step_once();
      end
   endtask

   // let every predicted response leave, then let the block settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (rsp_pending != 0);
      repeat (SETTLE_LEN) @(posedge clock);
   endtask

   task automatic write_style(input line_style_type style);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= style;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      style_writes++;
   endtask

   // response side pacing, with one long hold-off when armed
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end else if (no_idle) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(8, 40)) @(posedge clock);
            else
               repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("watchdog: no request or response moved for %0d cycles", IDLE_LIMIT);
         $display("[styled_line_rasterizer_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and verdict
   initial begin
      line_style_type style_plan[8];
      line_style_type style;
      int phase;
      int phase_start;
      bit hold_done;
      style_plan = '{STYLE_DOTTED, STYLE_DASHED, STYLE_NONE, STYLE_SPARE_C,
                     STYLE_BROAD, STYLE_SPARE_A, STYLE_SPARE_B, STYLE_SOLID};
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_START;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x   = '0;
      req_bus.end_y   = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = '0;

      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      // directed: solid style after reset
      step_once();                                 // step with no line loaded
      draw_line(0, 0, 0, 0, 1);                    // zero-length line
      draw_line(0, 0, 3, 0, 4);                    // flat line, one step past its end
      draw_line(COORD_MAX, COORD_MAX, 1020, 1017, 2);   // steep, both directions negative
      draw_line(0, COORD_MAX, COORD_MAX, 0, 2);    // longest diagonal, abandoned
      draw_line(5, 5, 2, 7, 3);                    // shallow, mixed directions
      drain();

      // directed: broad style at the corners of the field
      write_style(STYLE_BROAD);
      draw_line(0, 0, 2, 1, 2);
      draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX, 2);
      drain();

      // random phases, each under its own style setting
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase < 8)
            style = style_plan[phase];
         else
            style = line_style_type'($urandom_range(0, 7));
         write_style(style);
         no_idle = (phase % 4 == 3);
         phase_start = items_sent;
         hold_done = 1'b0;
         while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
            // stall the response side while requests keep coming
            if ((phase == 0 || phase == 4) && !hold_done && items_sent - phase_start >= 10) begin
               hold_armed = 1'b1;
               hold_done  = 1'b1;
            end
            random_line();
         end
         drain();
         phase++;
      end

      no_idle = 1'b0;
      repeat (TAIL_LEN) @(posedge clock);

      $display("covered %0d requests (%0d starts, %0d steps) under %0d style writes",
               items_sent, starts_sent, steps_sent, style_writes);
      $display("checked %0d responses, %0d of them plotted pixels", responses_seen, pixels_seen);
      if (fail_count == 0 && rsp_pending == 0) begin
         $display("[styled_line_rasterizer_unit] OK");
      end else begin
         $display("%0d mismatches, %0d responses still expected", fail_count, rsp_pending);
         $display("[styled_line_rasterizer_unit] ERROR");
      end
      $finish;
   end

endmodule
